// ----- src/sas_pkg.sv -----
// Shared types and constants for the sprite animation sequencer.
// No dependencies; imported by sas_slot_update and the sequencer unit.
package sas_pkg;

    // Slot table size and derived widths
    localparam int NUM_SLOTS  = 32;
    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W     = 5;
    localparam int REPORT_N   = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_idx          TOP_IDX     = IDX_W'(NUM_SLOTS - 1);
    localparam logic [IDX_W:0] REPORT_LIM = (IDX_W + 1)'(REPORT_N);
    localparam logic [6:0]    NUM_SLOTS_L = 7'(NUM_SLOTS);

    // Command codes
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    // One slot entry as held in the slot RAM
    typedef struct packed {
        logic [15:0] base;
        logic [7:0]  frames;
        logic [7:0]  delay;
        logic        rpt;
        logic [7:0]  counter;
        logic [7:0]  timer;
        logic [15:0] tile;
    } t_slot_rec;

    localparam int REC_W = $bits(t_slot_rec);

endpackage

// ----- src/sas_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module sas_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                      i_wdata,
    input  logic                              i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                      o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sas_slot_update.sv -----
// Per-slot animation step applied to one entry read from the slot RAM.
// Depends on sas_pkg for the slot entry type.
module sas_slot_update (
    input  sas_pkg::t_slot_rec i_rec,
    input  logic               i_active,
    output sas_pkg::t_slot_rec o_rec
);
    import sas_pkg::*;

    logic [7:0] w_cnt_dec;

    assign w_cnt_dec = i_rec.counter - 8'd1;

    // Advance timer, then counter, then tile
    always_comb begin
        o_rec = i_rec;
        if (i_active && (i_rec.counter != 8'd0)) begin
            if (i_rec.timer != 8'd0) begin
                o_rec.timer = i_rec.timer - 8'd1;
            end else if (w_cnt_dec == 8'd0) begin
                if (i_rec.rpt) begin
                    o_rec.counter = i_rec.frames;
                    o_rec.timer   = i_rec.delay;
                    o_rec.tile    = i_rec.base;
                end else begin
                    o_rec.counter = 8'd0;
                end
            end else begin
                o_rec.counter = w_cnt_dec;
                o_rec.timer   = i_rec.delay;
                o_rec.tile    = i_rec.tile + 16'd1;
            end
        end
    end

endmodule

// ----- src/sprite_animation_sequencer_unit.sv -----
// Sprite animation sequencer: load and release complete on acceptance; a query
// reads the slot RAM and its result word is registered once the output register
// is free, when the input reopens; a tick walks the slots from the top index down,
// one slot per cycle unless stalled (read, update, write back in the slot RAM).
// A result word waits in the output register; a stalled output holds the walk.
// Reset (synchronous, active low) clears the control state and all active
// marks; the slot RAM is not cleared and reads undefined until loaded.
module sprite_animation_sequencer_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sas_pkg::t_cmd  i_cmd,
    input  sas_pkg::t_slot i_slot,
    input  logic [15:0]    i_base_tile,
    input  logic [7:0]     i_frame_count,
    input  logic [7:0]     i_frame_delay,
    input  logic           i_repeat_req,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sas_pkg::t_slot o_out_slot,
    output logic           o_active,
    output logic [15:0]    o_tile,
    output logic           o_ended,
    output logic           o_last
);
    import sas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_QRY  = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_idx        r_idx, n_idx;
    t_slot       r_qslot, n_qslot;
    logic        r_qok, n_qok;
    logic        r_active [NUM_SLOTS];

    logic        r_out_valid;
    t_slot       r_out_slot;
    logic        r_out_active;
    logic [15:0] r_out_tile;
    logic        r_out_ended;
    logic        r_out_last;

    logic        w_acc, w_slot_ok, w_out_free, w_need_emit;
    t_idx        w_slot_idx;
    logic        w_we, w_re;
    t_idx        w_waddr, w_raddr;
    t_slot_rec   w_wdata, w_rdata, w_upd, w_load_rec;
    logic        w_cur_active;

    logic        w_emit, w_emit_act, w_emit_end, w_emit_last;
    t_slot       w_emit_slot;
    logic [15:0] w_emit_tile;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_slot_ok   = ({2'b00, i_slot} < NUM_SLOTS_L);
    assign w_slot_idx  = IDX_W'(i_slot);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_need_emit = ({1'b0, r_idx} < REPORT_LIM);
    assign w_cur_active = r_active[r_idx];

    assign w_load_rec = '{base: i_base_tile, frames: i_frame_count, delay: i_frame_delay,
                          rpt: i_repeat_req, counter: i_frame_count,
                          timer: i_frame_delay, tile: i_base_tile};

    sas_ram #(
        .W (REC_W),
        .D (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sas_slot_update u_update (
        .i_rec    (w_rdata),
        .i_active (w_cur_active),
        .o_rec    (w_upd)
    );

    // Sequence commands and the tick walk
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_qslot     = r_qslot;
        n_qok       = r_qok;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_upd;
        w_re        = 1'b0;
        w_raddr     = r_idx;
        w_emit      = 1'b0;
        w_emit_slot = SLOT_W'(r_idx);
        w_emit_act  = w_cur_active;
        w_emit_tile = w_upd.tile;
        w_emit_end  = (w_upd.counter == 8'd0);
        w_emit_last = (r_idx == '0);
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_cmd)
                        CMD_LOAD: begin
                            w_we    = w_slot_ok;
                            w_waddr = w_slot_idx;
                            w_wdata = w_load_rec;
                        end
                        CMD_RELEASE: begin
                        end
                        CMD_TICK: begin
                            w_re    = 1'b1;
                            w_raddr = TOP_IDX;
                            n_idx   = TOP_IDX;
                            n_state = S_RUN;
                        end
                        CMD_QUERY: begin
                            w_re    = w_slot_ok;
                            w_raddr = w_slot_idx;
                            n_idx   = w_slot_idx;
                            n_qslot = i_slot;
                            n_qok   = w_slot_ok;
                            n_state = S_QRY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_QRY: begin
                w_emit_slot = r_qslot;
                w_emit_act  = r_qok && w_cur_active;
                w_emit_tile = r_qok ? w_rdata.tile : 16'd0;
                w_emit_end  = r_qok && (w_rdata.counter == 8'd0);
                w_emit_last = 1'b1;
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                // Advance only when the result word can be placed
                if (!w_need_emit || w_out_free) begin
                    w_we   = 1'b1;
                    w_emit = w_need_emit;
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = r_idx - 1'b1;
                        n_idx   = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_qok   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_qok   <= n_qok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qslot <= n_qslot;
    end

    // Active marks: set on load, drop on release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_active[i] <= 1'b0;
            end
        end else if (w_acc && w_slot_ok) begin
            if (i_cmd == CMD_LOAD) begin
                r_active[w_slot_idx] <= 1'b1;
            end else if (i_cmd == CMD_RELEASE) begin
                r_active[w_slot_idx] <= 1'b0;
            end
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_slot   <= w_emit_slot;
            r_out_active <= w_emit_act;
            r_out_tile   <= w_emit_tile;
            r_out_ended  <= w_emit_end;
            r_out_last   <= w_emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_slot  = r_out_slot;
    assign o_active    = r_out_active;
    assign o_tile      = r_out_tile;
    assign o_ended     = r_out_ended;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    // A stalled walk must not overwrite the read data it still needs
    a_stall_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && w_need_emit && !w_out_free) |-> (!w_re && !w_we))
        else $error("slot RAM accessed while tick walk is stalled");

    // Read and write never hit the same entry in one cycle
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("slot RAM read and write collide");

    // The final word of a command returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_last) |=> (r_state == S_IDLE))
        else $error("last word emitted without returning to idle");
`endif

endmodule
